### src/nbfa_pkg.sv
// Shared types, constants and register codes of the nine-bit frame assembler.
package nbfa_pkg;

  // Default store depth in bytes.
  localparam int MAX_FRAME_BYTES_DEF = 36;

  // Width of the frame length field on the result channel.
  localparam int LEN_W = 6;

  // Configuration register indexes and widths.
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ACK     = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [15:0] TIMEOUT_RESET = 16'd10;
  localparam logic [7:0]  ACK_RESET     = 8'd0;

  // Input item opcodes.
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
    logic       mode_bit;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       frame_byte;
    logic             last_byte;
    logic [LEN_W-1:0] frame_length;
    logic             checksum_good;
  } out_item_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic take;   // input transfer this cycle
    logic rd;     // read the store at the emission index
    logic step;   // result transfer, move to the next byte
  } nbfa_cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic close;  // the offered item closes a frame
    logic last;   // emission index points at the final byte
  } nbfa_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SHOW
  } nbfa_state_t;

endpackage

### src/nbfa_ctrl.sv
// Controller state machine: input acceptance and the walk over a closed frame.
module nbfa_ctrl
  import nbfa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  nbfa_stat_t stat,
  output nbfa_cmd_t  cmd
);

  nbfa_state_t state_r;
  nbfa_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && stat.close) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_ready) begin
          state_nxt = stat.last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs and commands.
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_READ: begin
        cmd.rd = 1'b1;
      end
      ST_SHOW: begin
        out_valid = 1'b1;
        cmd.step  = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### src/nbfa_datapath.sv
// Datapath: frame store, byte and idle counters, checksum and result register.
module nbfa_datapath
  import nbfa_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  in_item_t              in_data,
  input  nbfa_cmd_t             cmd,
  output nbfa_stat_t            stat,
  output out_item_t             out_data
);

  localparam int CNT_W  = $clog2(MAX_FRAME_BYTES + 1);
  localparam int ADDR_W = $clog2(MAX_FRAME_BYTES);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_BYTES);

  logic [15:0]       timeout_r;
  logic [7:0]        ack_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [15:0]       idle_r, idle_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [CNT_W-1:0]  len_r;
  logic              good_r;
  logic [ADDR_W-1:0] idx_r;
  logic [7:0]        rd_data_r;
  logic [7:0]        store_mem [MAX_FRAME_BYTES];

  logic        is_char;
  logic        full;
  logic        wr_en;
  logic        empty;
  logic [15:0] idle_inc;

  assign is_char = (in_data.opcode == OP_CHAR);
  assign full    = (count_r >= MAX_CNT);
  assign empty   = (count_r == '0);
  assign wr_en   = cmd.take && is_char && !full;

  // A stored character closes the frame on its ninth bit, or as a lone acknowledge.
  assign stat.close = is_char && !full &&
                      (in_data.mode_bit || (empty && (in_data.data_byte == ack_r)));
  assign stat.last  = ((CNT_W'(idx_r) + CNT_W'(1)) == len_r);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
      ack_r     <= ACK_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TIMEOUT: timeout_r <= cfg_wdata;
        CFG_ACK:     ack_r     <= cfg_wdata[7:0];
        default:     ack_r     <= ack_r;
      endcase
    end
  end

  // Saturating idle count for a tick.
  assign idle_inc = (idle_r != 16'hFFFF) ? (idle_r + 16'd1) : idle_r;

  // Next values of the byte count, idle count and running sum.
  always_comb begin
    count_nxt = count_r;
    idle_nxt  = idle_r;
    sum_nxt   = sum_r;
    if (cmd.take) begin
      if (!is_char) begin
        if (empty) begin
          idle_nxt = '0;
        end else if (idle_inc >= timeout_r) begin
          count_nxt = '0;
          idle_nxt  = '0;
        end else begin
          idle_nxt = idle_inc;
        end
      end else begin
        idle_nxt = '0;
        if (full) begin
          count_nxt = '0;
        end else if (stat.close) begin
          count_nxt = '0;
        end else begin
          count_nxt = count_r + CNT_W'(1);
          sum_nxt   = empty ? in_data.data_byte : (sum_r + in_data.data_byte);
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idle_r  <= '0;
    end else begin
      count_r <= count_nxt;
      idle_r  <= idle_nxt;
    end
  end

  // Frame summary and emission index.
  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    if (cmd.take && stat.close) begin
      len_r  <= count_r + CNT_W'(1);
      good_r <= empty || (sum_r == in_data.data_byte);
      idx_r  <= '0;
    end else if (cmd.step) begin
      idx_r <= idx_r + ADDR_W'(1);
    end
  end

  // Frame store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[count_r[ADDR_W-1:0]] <= in_data.data_byte;
    end
    if (cmd.rd) begin
      rd_data_r <= store_mem[idx_r];
    end
  end

  // Result fields; length and verdict only on the final byte.
  always_comb begin
    out_data.frame_byte    = rd_data_r;
    out_data.last_byte     = stat.last;
    out_data.frame_length  = stat.last ? LEN_W'(len_r) : '0;
    out_data.checksum_good = stat.last && good_r;
  end

endmodule

### src/nine_bit_frame_assembler.sv
// Top level of the nine-bit frame assembler: controller plus datapath.
// Characters and ticks are taken only in the idle state; a closing character starts a frame walk.
// Each frame byte is read from the store in READ and then offered in SHOW, byte by byte.
// Input stays held off until the final byte of the frame is taken, output stalls included.
// Reset (rst_n low, synchronous) empties the frame and loads timeout 10 and ack code 0.
module nine_bit_frame_assembler
  import nbfa_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data
);

  nbfa_cmd_t  cmd;
  nbfa_stat_t stat;

  // Sequencer.
  nbfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Storage and arithmetic.
  nbfa_datapath #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

  // Input and result channels are never open at the same time.
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input and result channels open together");

  // The final byte transfer returns the block to accepting input.
  a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last_byte |=> in_ready)
    else $error("block did not return to idle after the final byte");

  // A tick never starts a frame walk.
  a_tick_stays: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.opcode == OP_TICK) |=> in_ready)
    else $error("tick transfer started a frame walk");

endmodule

### sim/tb_nine_bit_frame_assembler.sv
`timescale 1ns / 1ps
// Self-checking testbench of the nine-bit frame assembler with its own frame predictor.
module tb_nine_bit_frame_assembler
  import nbfa_pkg::*;
();

  localparam int STORE_DEPTH   = MAX_FRAME_BYTES_DEF;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int MAX_PRINTS    = 30;

  // One pending input transfer with the idle gap that goes before it.
  typedef struct {
    in_item_t    item;
    int unsigned gap;
    bit          drain;
  } char_slot_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;

  // Predictor state: stored bytes, fill level, idle time and register copies.
  logic [7:0]  store_model [STORE_DEPTH];
  int unsigned held_bytes = 0;
  int unsigned idle_count = 0;
  logic [15:0] timeout_model = TIMEOUT_RESET;
  logic [7:0]  ack_model = ACK_RESET;
  out_item_t   frame_byte_q [$];

  char_slot_t  rx_char_q [$];
  char_slot_t  slot;
  in_item_t    drv_item = '0;
  bit          drv_offering = 1'b0;
  bit          drv_armed = 1'b0;
  int unsigned gap_left = 0;
  bit          tx_idling = 1'b1;
  bit          rx_idling = 1'b1;
  bit          drain_next = 1'b0;
  int unsigned hold_reqs = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  out_item_t   want_item;

  int unsigned results_due = 0;
  int unsigned results_seen = 0;
  int unsigned queued_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned tick_cnt = 0;
  int unsigned frame_cnt = 0;
  int unsigned discard_cnt = 0;
  int unsigned overflow_cnt = 0;
  int unsigned cfg_writes = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;

  nine_bit_frame_assembler u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Free-running clock.
  initial begin
    forever #2 clk = ~clk;
  end

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want_v);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) begin
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want_v);
    end
  endtask

  // Applies one accepted transfer to the predictor and queues the bytes of a closed frame.
  task automatic assemble_frame(input in_item_t it);
    logic [7:0] sum;
    bit         good;
    bit         close;
    out_item_t  res;
    if (it.opcode == OP_TICK) begin
      tick_cnt++;
      if (held_bytes == 0) begin
        idle_count = 0;
      end else begin
        if (idle_count < 16'hFFFF) idle_count++;
        if (idle_count >= timeout_model) begin
          held_bytes = 0;
          idle_count = 0;
          discard_cnt++;
        end
      end
    end else begin
      idle_count = 0;
      if (held_bytes >= STORE_DEPTH) begin
        // A full store drops the character and starts over.
        held_bytes = 0;
        overflow_cnt++;
      end else begin
        store_model[held_bytes] = it.data_byte;
        held_bytes++;
        close = it.mode_bit || (held_bytes == 1 && it.data_byte == ack_model);
        if (close) begin
          sum = '0;
          for (int i = 0; i + 1 < held_bytes; i++) sum += store_model[i];
          good = (held_bytes == 1) || (sum == store_model[held_bytes-1]);
          for (int i = 0; i < held_bytes; i++) begin
            res.frame_byte    = store_model[i];
            res.last_byte     = (i + 1 == held_bytes);
            res.frame_length  = res.last_byte ? LEN_W'(held_bytes) : '0;
            res.checksum_good = res.last_byte && good;
            frame_byte_q.push_back(res);
          end
          results_due += held_bytes;
          frame_cnt++;
          held_bytes = 0;
        end
      end
    end
  endtask

  // Sender: offers queued items after their gaps and predicts each input transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (drv_offering && in_ready) begin
        assemble_frame(drv_item);
        accepted_cnt++;
        drv_offering = 1'b0;
      end
      if (!drv_offering && !drv_armed && rx_char_q.size() > 0 &&
          !(rx_char_q[0].drain && results_seen != results_due)) begin
        slot      = rx_char_q.pop_front();
        drv_item  = slot.item;
        gap_left  = slot.gap;
        drv_armed = 1'b1;
      end
      if (drv_armed) begin
        if (gap_left == 0) begin
          drv_armed    = 1'b0;
          drv_offering = 1'b1;
        end else begin
          gap_left--;
        end
      end
      in_valid <= drv_offering;
      in_data  <= drv_item;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_served != hold_reqs) begin
        hold_left   = LONG_HOLD;
        hold_served = hold_reqs;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (rx_idling && $urandom_range(0, 99) < 25) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 48) :
                                                   $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Result checker: each result transfer is compared with the oldest expected byte.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (frame_byte_q.size() == 0) begin
        report_mismatch("result with nothing expected", out_data.frame_byte, 0);
      end else begin
        want_item = frame_byte_q.pop_front();
        if (out_data.frame_byte !== want_item.frame_byte)
          report_mismatch("frame_byte", out_data.frame_byte, want_item.frame_byte);
        if (out_data.last_byte !== want_item.last_byte)
          report_mismatch("last_byte", out_data.last_byte, want_item.last_byte);
        if (out_data.frame_length !== want_item.frame_length)
          report_mismatch("frame_length", out_data.frame_length, want_item.frame_length);
        if (out_data.checksum_good !== want_item.checksum_good)
          report_mismatch("checksum_good", out_data.checksum_good, want_item.checksum_good);
      end
    end
  end

  // Watchdog on the total cycle count.
  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Run stopped by the watchdog after %0d cycles.", CYCLE_LIMIT);
    $display("** nine_bit_frame_assembler: FAILED **");
    $finish;
  end

  // Idle gap before an item: mostly none or short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!tx_idling) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic push_item(input logic op, input logic [7:0] b, input logic m);
    char_slot_t s;
    s.item.opcode    = op;
    s.item.data_byte = b;
    s.item.mode_bit  = m;
    s.gap            = pick_gap();
    s.drain          = drain_next;
    drain_next       = 1'b0;
    rx_char_q.push_back(s);
    queued_cnt++;
  endtask

  // A tick carries random data and ninth bits, which the block ignores.
  task automatic push_tick();
    push_item(OP_TICK, 8'($urandom), 1'($urandom));
  endtask

  // Well-formed frame, optionally with a matching checksum and ticks below the timeout.
  task automatic add_frame(input int unsigned len, input bit good);
    logic [7:0] b;
    logic [7:0] sum;
    sum = '0;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (i == 0 && len > 1 && b == ack_model) b = ~b;
      if (i + 1 == len && len > 1 && good) b = sum;
      sum += b;
      push_item(OP_CHAR, b, i + 1 == len);
      if (i + 1 < len && timeout_model > 1 && $urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, (timeout_model > 6) ? 5 : timeout_model - 1)) push_tick();
      end
    end
  endtask

  // Partial frame left idle until the timeout discards it.
  task automatic add_stale_frame();
    logic [7:0] b;
    int unsigned len;
    len = $urandom_range(1, 5);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (i == 0 && b == ack_model) b = ~b;
      push_item(OP_CHAR, b, 1'b0);
    end
    repeat ((timeout_model == 0) ? 1 : timeout_model) push_tick();
  endtask

  // Fills the store and sends one more character, which is dropped.
  task automatic add_overflow();
    logic [7:0] b;
    for (int i = 0; i <= STORE_DEPTH; i++) begin
      b = 8'($urandom);
      if (i == 0 && b == ack_model) b = ~b;
      push_item(OP_CHAR, b, (i == STORE_DEPTH) ? 1'($urandom) : 1'b0);
    end
  endtask

  // Mostly well-formed frames, with ack frames, timeouts and noise mixed in.
  task automatic add_random(input int unsigned n_items);
    int unsigned start;
    int unsigned r;
    int unsigned len;
    start = queued_cnt;
    while (queued_cnt - start < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        r   = $urandom_range(0, 99);
        len = (r < 70) ? $urandom_range(1, 6) :
              (r < 95) ? $urandom_range(7, 15) : $urandom_range(16, STORE_DEPTH);
        add_frame(len, $urandom_range(0, 99) < 70);
      end else if (r < 65) begin
        push_item(OP_CHAR, ack_model, 1'($urandom));
      end else if (r < 77) begin
        if (timeout_model <= 40) add_stale_frame();
        else add_frame($urandom_range(1, 4), 1'b1);
      end else begin
        push_item(1'($urandom), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  // Waits until every item is sent, every result is back and the block has been quiet.
  task automatic wait_settled();
    int unsigned quiet;
    quiet = 0;
    while (quiet < SETTLE_CYCLES) begin
      @(negedge clk);
      if (rx_char_q.size() == 0 && !drv_armed && !drv_offering &&
          results_seen == results_due && !out_valid) quiet++;
      else quiet = 0;
    end
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_TIMEOUT) timeout_model = val;
    else ack_model = val[7:0];
    cfg_writes++;
  endtask

  task automatic set_config(input logic [15:0] ticks, input logic [7:0] ack);
    write_reg(CFG_TIMEOUT, ticks);
    write_reg(CFG_ACK, {8'h00, ack});
    @(negedge clk);
  endtask

  // Phases of stimulus, each under its own register setting.
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: ack frames, ninth-bit ends, checksums, ack value not first.
    push_item(OP_CHAR, 8'h00, 1'b0);
    push_tick();
    push_item(OP_CHAR, 8'hFF, 1'b1);
    push_item(OP_CHAR, 8'h12, 1'b0);
    push_item(OP_CHAR, 8'h34, 1'b0);
    push_item(OP_CHAR, 8'h46, 1'b1);
    push_item(OP_CHAR, 8'h80, 1'b0);
    push_item(OP_CHAR, 8'h80, 1'b0);
    push_item(OP_CHAR, 8'h01, 1'b1);
    push_item(OP_CHAR, 8'h33, 1'b0);
    push_item(OP_CHAR, 8'h00, 1'b0);
    push_item(OP_CHAR, 8'h33, 1'b1);
    push_item(OP_CHAR, 8'h00, 1'b1);
    push_item(OP_CHAR, 8'h55, 1'b0);
    push_tick();
    push_item(OP_CHAR, 8'h66, 1'b1);
    add_random(2);
    wait_settled();

    // Short timeout and the top ack value: frames just surviving and just expiring.
    set_config(16'd3, 8'hFF);
    push_item(OP_CHAR, 8'hFF, 1'b0);
    push_item(OP_CHAR, 8'h10, 1'b0);
    push_tick();
    push_tick();
    push_item(OP_CHAR, 8'h20, 1'b1);
    push_item(OP_CHAR, 8'h10, 1'b0);
    repeat (3) push_tick();
    push_item(OP_CHAR, 8'h30, 1'b1);
    push_tick();
    add_random(2);
    wait_settled();

    // Zero timeout, with the receiver held off while the sender keeps offering.
    set_config(16'd0, 8'hA5);
    hold_reqs++;
    tx_idling = 1'b0;
    push_item(OP_CHAR, 8'h11, 1'b0);
    push_tick();
    push_item(OP_CHAR, 8'hA5, 1'b0);
    add_random(4);
    wait_settled();
    tx_idling = 1'b1;

    // Timeout of one tick: a full-length frame, an overflow, and a drain mid-phase.
    set_config(16'd1, 8'($urandom));
    add_frame(STORE_DEPTH, 1'b1);
    add_overflow();
    drain_next = 1'b1;
    add_random(2);
    wait_settled();

    // Longest timeout, back to back: ticks between bytes leave the frame intact.
    set_config(16'hFFFF, 8'h5A);
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    push_item(OP_CHAR, 8'h01, 1'b0);
    repeat (5) push_tick();
    push_item(OP_CHAR, 8'h02, 1'b1);
    push_item(OP_CHAR, 8'h03, 1'b0);
    repeat (2) push_tick();
    push_item(OP_CHAR, 8'h04, 1'b1);
    wait_settled();
    rx_idling = 1'b1;

    // Random timeout and ack value, first without sender gaps and then with them.
    set_config(16'($urandom_range(2, 40)), 8'($urandom));
    add_random(2);
    tx_idling = 1'b1;
    add_random(2);
    wait_settled();

    if (frame_byte_q.size() != 0)
      report_mismatch("results never delivered", frame_byte_q.size(), 0);
    $display("Covered %0d input transfers (%0d ticks) and %0d result transfers over %0d writes.",
             accepted_cnt, tick_cnt, results_seen, cfg_writes);
    $display("Frames closed: %0d, discarded on timeout: %0d, dropped on a full store: %0d.",
             frame_cnt, discard_cnt, overflow_cnt);
    if (err_cnt == 0) begin
      $display("** nine_bit_frame_assembler: PASSED **");
    end else begin
      $display("** nine_bit_frame_assembler: FAILED **");
    end
    $finish;
  end

endmodule
